### rtl/hft_pkg.sv
// Shared types and constants for the host fanout tracker.
package hft_pkg;

  localparam int HOSTS_DEFAULT = 64;
  localparam int ADDR_W        = 32;
  localparam int DEG_W         = 6;
  localparam int SLOT_FIELD_W  = 6;

  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [DEG_W-1:0]        degree_t;
  typedef logic [SLOT_FIELD_W-1:0] slot_field_t;

  localparam degree_t DEG_MAX         = '1;
  localparam degree_t THRESHOLD_RESET = 6'd4;

  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_SELF  = 2'd1,
    ST_FULL  = 2'd2,
    ST_KNOWN = 2'd3
  } status_t;

  typedef struct packed {
    addr_t host_a;
    addr_t host_b;
  } item_t;

  typedef struct packed {
    status_t     status;
    slot_field_t slot_a;
    slot_field_t slot_b;
    degree_t     degree_a;
    degree_t     degree_b;
    logic        newly_flagged_a;
    logic        newly_flagged_b;
  } result_t;

  // per-host record: sticky suspicious mark and peer count
  typedef struct packed {
    logic    mark;
    degree_t degree;
  } host_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_RD_A,
    S_UPD_A,
    S_RD_B,
    S_UPD_B,
    S_DONE
  } state_t;

endpackage

### rtl/host_fanout_tracker.sv
// Host fanout tracker: host table, adjacency rows and degree tracking.
// Flow: a self connection goes straight to DONE; otherwise a linear search over the used
//   slots for each endpoint (one address read per cycle, one read port), then the
//   adjacency and degree updates (RD_A, UPD_A, RD_B, UPD_B) and the result load.
// Items: one at a time; the next beat is taken only in IDLE.
// Reset: synchronous; clears control, slot count and threshold (4); slots zeroed when taken.
module host_fanout_tracker #(
  parameter int HOSTS = hft_pkg::HOSTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  hft_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_ready,
  output hft_pkg::result_t  result,
  input  logic              cfg_we,
  input  hft_pkg::degree_t  cfg_wdata
);

  localparam int SLOT_W = $clog2(HOSTS);
  localparam int CNT_W  = $clog2(HOSTS + 1);
  localparam logic [CNT_W-1:0] TABLE_FULL = CNT_W'(HOSTS);

  // storage
  hft_pkg::addr_t      addr_mem [HOSTS];
  logic [HOSTS-1:0]    adj_mem  [HOSTS];
  hft_pkg::host_stat_t stat_mem [HOSTS];

  hft_pkg::state_t     state, state_next;
  hft_pkg::degree_t    threshold;
  logic [CNT_W-1:0]    used;
  logic                probe_valid;

  hft_pkg::item_t      item_q;
  logic [CNT_W-1:0]    idx;
  logic [SLOT_W-1:0]   probe_slot;
  logic                phase;
  logic                ok_a;
  logic                known;
  logic [SLOT_W-1:0]   slot_a_q, slot_b_q;
  hft_pkg::result_t    res;
  hft_pkg::result_t    res_init;

  hft_pkg::addr_t      addr_q;
  logic [HOSTS-1:0]    adj_q;
  hft_pkg::host_stat_t stat_q;

  hft_pkg::addr_t      key;
  logic                hit, exhausted, issue, full, found_ok, insert_now;
  logic [SLOT_W-1:0]   found_slot;
  logic [HOSTS-1:0]    bit_a, bit_b;
  hft_pkg::degree_t    deg_inc;
  logic                flag_new;
  hft_pkg::host_stat_t bumped;

  logic                addr_we;
  logic                adj_we, stat_we;
  logic [SLOT_W-1:0]   adj_waddr, stat_waddr, rd_slot;
  logic [HOSTS-1:0]    adj_wdata;
  hft_pkg::host_stat_t stat_wdata;

  // search datapath: addr_q holds the entry read for probe_slot
  always_comb begin
    key        = phase ? item_q.host_b : item_q.host_a;
    hit        = probe_valid && (addr_q == key);
    exhausted  = !probe_valid && (idx == used);
    issue      = (idx != used) && !hit;
    full       = (used == TABLE_FULL);
    found_ok   = hit || !full;
    found_slot = hit ? probe_slot : used[SLOT_W-1:0];
    insert_now = (state == hft_pkg::S_SEARCH) && exhausted && !full;
  end

  // result seed for an accepted beat
  always_comb begin
    res_init = '0;
    if (item.host_a == item.host_b) begin
      res_init.status = hft_pkg::ST_SELF;
    end
  end

  always_comb begin
    bit_a = '0;
    bit_a[slot_a_q] = 1'b1;
    bit_b = '0;
    bit_b[slot_b_q] = 1'b1;
  end

  // degree bump with saturation and sticky mark
  always_comb begin
    deg_inc = (stat_q.degree == hft_pkg::DEG_MAX) ? stat_q.degree :
              hft_pkg::degree_t'(stat_q.degree + 1'b1);
    flag_new      = (deg_inc > threshold) && !stat_q.mark;
    bumped.mark   = stat_q.mark | flag_new;
    bumped.degree = deg_inc;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      hft_pkg::S_IDLE: begin
        if (item_valid) begin
          state_next = (item.host_a == item.host_b) ? hft_pkg::S_DONE : hft_pkg::S_SEARCH;
        end
      end
      hft_pkg::S_SEARCH: begin
        if ((hit || exhausted) && phase) begin
          state_next = (ok_a && found_ok) ? hft_pkg::S_RD_A : hft_pkg::S_DONE;
        end
      end
      hft_pkg::S_RD_A:  state_next = hft_pkg::S_UPD_A;
      hft_pkg::S_UPD_A: state_next = hft_pkg::S_RD_B;
      hft_pkg::S_RD_B:  state_next = hft_pkg::S_UPD_B;
      hft_pkg::S_UPD_B: state_next = hft_pkg::S_DONE;
      hft_pkg::S_DONE: begin
        if (!result_valid || result_ready) begin
          state_next = hft_pkg::S_IDLE;
        end
      end
      default: state_next = hft_pkg::S_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    item_ready = (state == hft_pkg::S_IDLE);
    addr_we    = 1'b0;
    adj_we     = 1'b0;
    adj_waddr  = slot_a_q;
    adj_wdata  = '0;
    stat_we    = 1'b0;
    stat_waddr = slot_a_q;
    stat_wdata = '0;
    rd_slot    = slot_a_q;
    case (state)
      hft_pkg::S_SEARCH: begin
        if (insert_now) begin
          // new slot starts with an empty row, zero degree, no mark
          addr_we    = 1'b1;
          adj_we     = 1'b1;
          adj_waddr  = used[SLOT_W-1:0];
          stat_we    = 1'b1;
          stat_waddr = used[SLOT_W-1:0];
        end
      end
      hft_pkg::S_RD_A: rd_slot = slot_a_q;
      hft_pkg::S_UPD_A: begin
        if (!adj_q[slot_b_q]) begin
          adj_we     = 1'b1;
          adj_waddr  = slot_a_q;
          adj_wdata  = adj_q | bit_b;
          stat_we    = 1'b1;
          stat_waddr = slot_a_q;
          stat_wdata = bumped;
        end
      end
      hft_pkg::S_RD_B: rd_slot = slot_b_q;
      hft_pkg::S_UPD_B: begin
        if (!known) begin
          adj_we     = 1'b1;
          adj_waddr  = slot_b_q;
          adj_wdata  = adj_q | bit_a;
          stat_we    = 1'b1;
          stat_waddr = slot_b_q;
          stat_wdata = bumped;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (addr_we) begin
      addr_mem[used[SLOT_W-1:0]] <= key;
    end
    addr_q <= addr_mem[idx[SLOT_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (adj_we) begin
      adj_mem[adj_waddr] <= adj_wdata;
    end
    adj_q <= adj_mem[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (stat_we) begin
      stat_mem[stat_waddr] <= stat_wdata;
    end
    stat_q <= stat_mem[rd_slot];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= hft_pkg::S_IDLE;
      threshold    <= hft_pkg::THRESHOLD_RESET;
      used         <= '0;
      probe_valid  <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        threshold <= cfg_wdata;
      end
      if (insert_now) begin
        used <= used + 1'b1;
      end
      probe_valid <= (state == hft_pkg::S_SEARCH) && issue;
      if (state == hft_pkg::S_DONE && state_next == hft_pkg::S_IDLE) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (state)
      hft_pkg::S_IDLE: begin
        if (item_valid) begin
          item_q <= item;
          phase  <= 1'b0;
          idx    <= '0;
          res    <= res_init;
        end
      end
      hft_pkg::S_SEARCH: begin
        probe_slot <= idx[SLOT_W-1:0];
        if (hit || exhausted) begin
          idx   <= '0;
          phase <= 1'b1;
          if (!phase) begin
            slot_a_q <= found_slot;
            ok_a     <= found_ok;
          end else begin
            slot_b_q <= found_slot;
            if (!(ok_a && found_ok)) begin
              res.status <= hft_pkg::ST_FULL;
            end
          end
        end else if (issue) begin
          idx <= idx + 1'b1;
        end
      end
      hft_pkg::S_UPD_A: begin
        known <= adj_q[slot_b_q];
        if (adj_q[slot_b_q]) begin
          res.degree_a <= stat_q.degree;
        end else begin
          res.degree_a        <= bumped.degree;
          res.newly_flagged_a <= flag_new;
        end
      end
      hft_pkg::S_UPD_B: begin
        res.slot_a <= hft_pkg::slot_field_t'(slot_a_q);
        res.slot_b <= hft_pkg::slot_field_t'(slot_b_q);
        if (known) begin
          res.status   <= hft_pkg::ST_KNOWN;
          res.degree_b <= stat_q.degree;
        end else begin
          res.status          <= hft_pkg::ST_ADDED;
          res.degree_b        <= bumped.degree;
          res.newly_flagged_b <= flag_new;
        end
      end
      hft_pkg::S_DONE: begin
        if (state_next == hft_pkg::S_IDLE) begin
          result <= res;
        end
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst) used <= TABLE_FULL)
    else $error("slot count beyond table size");

  assert property (@(posedge clk) disable iff (rst) item_valid && item_ready |=> !item_ready)
    else $error("ready again right after an accepted beat");

  assert property (@(posedge clk) disable iff (rst)
    state == hft_pkg::S_UPD_B |-> slot_a_q != slot_b_q)
    else $error("both endpoints resolved to one slot");

  assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.newly_flagged_a || result.newly_flagged_b)
      |-> result.status == hft_pkg::ST_ADDED)
    else $error("flag raised on a result that added no pair");
`endif

endmodule

### sim/tb_host_fanout_tracker.sv
// Testbench for host_fanout_tracker: directed table, then random connection traffic.
`timescale 1ns / 100ps

module tb_host_fanout_tracker;

  localparam int HOSTS = 64;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int TAIL_CYCLES = 2 * HOSTS + 20;
  localparam int POOL_SIZE = 140;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    hft_pkg::item_t    conn;
    logic              typed;
    hft_pkg::result_t  res;
    hft_pkg::degree_t  thr;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             item_valid = 1'b0;
  logic             item_ready;
  hft_pkg::item_t   item = '0;
  logic             result_valid;
  logic             result_ready = 1'b0;
  hft_pkg::result_t result;
  logic             cfg_we = 1'b0;
  hft_pkg::degree_t cfg_wdata = '0;

  // tracker state as seen by the testbench
  hft_pkg::addr_t   host_tab [HOSTS];
  logic [HOSTS-1:0] peer_row [HOSTS];
  hft_pkg::degree_t host_deg [HOSTS];
  logic             host_mark [HOSTS];
  int               used_cnt = 0;
  hft_pkg::degree_t flag_threshold = hft_pkg::THRESHOLD_RESET;

  hft_pkg::result_t pending_results [$];
  stim_row_t        plan [$];
  hft_pkg::addr_t   host_list [$];
  int               mismatches = 0;
  int               cycle_count = 0;
  bit               steady = 1'b0;
  hft_pkg::result_t want;

  host_fanout_tracker #(.HOSTS(HOSTS)) u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic hft_pkg::item_t mk_item(hft_pkg::addr_t a, hft_pkg::addr_t b);
    hft_pkg::item_t it;
    it.host_a = a;
    it.host_b = b;
    return it;
  endfunction

  function automatic int find_or_add_host(hft_pkg::addr_t a);
    for (int i = 0; i < used_cnt; i++)
      if (host_tab[i] == a) return i;
    if (used_cnt >= HOSTS) return -1;
    host_tab[used_cnt] = a;
    host_deg[used_cnt] = '0;
    host_mark[used_cnt] = 1'b0;
    used_cnt++;
    return used_cnt - 1;
  endfunction

  // degree stops at DEG_MAX; the mark is sticky
  function automatic logic raise_degree(int s);
    if (host_deg[s] < hft_pkg::DEG_MAX) host_deg[s] = host_deg[s] + 1'b1;
    if (host_deg[s] > flag_threshold && !host_mark[s]) begin
      host_mark[s] = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic hft_pkg::result_t track_connection(hft_pkg::item_t it);
    hft_pkg::result_t r;
    int sa;
    int sb;
    r = '0;
    if (it.host_a == it.host_b) begin
      r.status = hft_pkg::ST_SELF;
      return r;
    end
    // host_a goes in first and stays even when host_b finds no room
    sa = find_or_add_host(it.host_a);
    sb = find_or_add_host(it.host_b);
    if (sa < 0 || sb < 0) begin
      r.status = hft_pkg::ST_FULL;
      return r;
    end
    if (peer_row[sa][sb]) begin
      r.status = hft_pkg::ST_KNOWN;
    end else begin
      peer_row[sa][sb] = 1'b1;
      peer_row[sb][sa] = 1'b1;
      r.newly_flagged_a = raise_degree(sa);
      r.newly_flagged_b = raise_degree(sb);
      r.status = hft_pkg::ST_ADDED;
    end
    r.slot_a = hft_pkg::slot_field_t'(sa);
    r.slot_b = hft_pkg::slot_field_t'(sb);
    r.degree_a = host_deg[sa];
    r.degree_b = host_deg[sb];
    return r;
  endfunction

  function automatic hft_pkg::result_t mk_result(hft_pkg::status_t st, int sa, int sb,
                                                 int da, int db);
    hft_pkg::result_t r;
    r = '0;
    r.status = st;
    r.slot_a = hft_pkg::slot_field_t'(sa);
    r.slot_b = hft_pkg::slot_field_t'(sb);
    r.degree_a = hft_pkg::degree_t'(da);
    r.degree_b = hft_pkg::degree_t'(db);
    return r;
  endfunction

  function automatic void row_item(hft_pkg::addr_t a, hft_pkg::addr_t b);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.conn = mk_item(a, b);
    plan.push_back(row);
  endfunction

  function automatic void row_typed(hft_pkg::addr_t a, hft_pkg::addr_t b,
                                    hft_pkg::result_t res);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.conn = mk_item(a, b);
    row.typed = 1'b1;
    row.res = res;
    plan.push_back(row);
  endfunction

  function automatic void row_cfg(hft_pkg::degree_t v);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.thr = v;
    plan.push_back(row);
  endfunction

  task automatic compare_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d",
               $time, name, exp_v, act_v);
    end
  endtask

  // result side: random stalls, check each beat against the oldest prediction
  always @(posedge clk) begin
    result_ready <= steady || ($urandom_range(99) >= 21);
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result beat, expected none, actual status %0d",
                 $time, result.status);
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, result.status);
        compare_field("slot_a", want.slot_a, result.slot_a);
        compare_field("slot_b", want.slot_b, result.slot_b);
        compare_field("degree_a", want.degree_a, result.degree_a);
        compare_field("degree_b", want.degree_b, result.degree_b);
        compare_field("newly_flagged_a", want.newly_flagged_a, result.newly_flagged_a);
        compare_field("newly_flagged_b", want.newly_flagged_b, result.newly_flagged_b);
      end
    end
  end

  task automatic offer_connection(hft_pkg::item_t it, logic typed,
                                  hft_pkg::result_t typed_res);
    hft_pkg::result_t exp_r;
    exp_r = track_connection(it);
    if (typed) exp_r = typed_res;
    while (!steady && $urandom_range(99) < 21) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    pending_results.push_back(exp_r);
  endtask

  task automatic wait_results_drained();
    item_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_threshold(hft_pkg::degree_t v);
    wait_results_drained();
    repeat (4) @(posedge clk);
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    flag_threshold = v;
  endtask

  // well-formed pairs over the first span hosts, plus a few self connections
  function automatic hft_pkg::item_t pick_pair(int span);
    int r;
    int ia;
    int ib;
    hft_pkg::addr_t x;
    r = $urandom_range(99);
    if (r < 5) begin
      x = host_list[$urandom_range(span - 1)];
      return mk_item(x, x);
    end
    if (r < 9) begin
      x = $urandom;
      return mk_item(x, x);
    end
    ia = $urandom_range(span - 1);
    ib = $urandom_range(span - 2);
    if (ib >= ia) ib++;
    return mk_item(host_list[ia], host_list[ib]);
  endfunction

  // table is full here: known hosts, self connections and unknown addresses
  function automatic hft_pkg::item_t pick_late_pair();
    int r;
    int ia;
    int ib;
    hft_pkg::addr_t x;
    r = $urandom_range(99);
    if (r < 15) begin
      x = ($urandom_range(1) == 1) ? hft_pkg::addr_t'($urandom) :
                                     host_tab[$urandom_range(HOSTS - 1)];
      return mk_item(x, x);
    end
    if (r < 25) return mk_item($urandom, $urandom);
    if (r < 35) return mk_item($urandom, host_tab[$urandom_range(HOSTS - 1)]);
    if (r < 40) return mk_item(host_tab[$urandom_range(HOSTS - 1)], $urandom);
    ia = $urandom_range(HOSTS - 1);
    ib = $urandom_range(HOSTS - 2);
    if (ib >= ia) ib++;
    return mk_item(host_tab[ia], host_tab[ib]);
  endfunction

  initial begin
    hft_pkg::degree_t phase_thr [4];
    hft_pkg::addr_t cand;
    bit dup;
    int nxt;

    foreach (peer_row[i]) peer_row[i] = '0;
    foreach (host_deg[i]) host_deg[i] = '0;
    foreach (host_mark[i]) host_mark[i] = 1'b0;

    // hosts used by the directed rows come first in the address pool
    host_list = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002,
                  32'h0000_0003, 32'h0000_0004, 32'h0000_0005, 32'hAAAA_AAAA,
                  32'h5555_5555, 32'h8000_0000, 32'h7FFF_FFFF, 32'hDEAD_BEEF};
    while (host_list.size() < POOL_SIZE) begin
      cand = $urandom;
      dup = 1'b0;
      foreach (host_list[i]) if (host_list[i] == cand) dup = 1'b1;
      if (!dup) host_list.push_back(cand);
    end

    row_typed(32'h0, 32'h0, mk_result(hft_pkg::ST_SELF, 0, 0, 0, 0));
    row_typed(32'hFFFF_FFFF, 32'hFFFF_FFFF, mk_result(hft_pkg::ST_SELF, 0, 0, 0, 0));
    row_typed(32'h0, 32'hFFFF_FFFF, mk_result(hft_pkg::ST_ADDED, 0, 1, 1, 1));
    row_typed(32'hFFFF_FFFF, 32'h0, mk_result(hft_pkg::ST_KNOWN, 1, 0, 1, 1));
    row_typed(32'h0, 32'hFFFF_FFFF, mk_result(hft_pkg::ST_KNOWN, 0, 1, 1, 1));
    // host 0 crosses the reset threshold of 4, then stays marked
    row_item(32'h0, 32'h1);
    row_item(32'h0, 32'h2);
    row_item(32'h0, 32'h3);
    row_item(32'h0, 32'h4);
    row_item(32'h0, 32'h5);
    row_item(32'hAAAA_AAAA, 32'h5555_5555);
    row_item(32'h5555_5555, 32'hAAAA_AAAA);
    row_item(32'h1, 32'h2);
    row_item(32'h2, 32'h1);
    row_item(32'h8000_0000, 32'h7FFF_FFFF);
    row_item(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    row_cfg(6'd0);
    row_item(32'h1, 32'h3);
    row_item(32'hDEAD_BEEF, 32'h0);
    row_cfg(6'd63);
    row_item(32'h3, 32'h4);
    row_cfg(hft_pkg::THRESHOLD_RESET);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) set_threshold(plan[i].thr);
      else offer_connection(plan[i].conn, plan[i].typed, plan[i].res);
    end

    // table grows phase by phase; the third phase runs with no stalls
    phase_thr = '{6'd2, 6'd0, 6'd63, hft_pkg::degree_t'($urandom_range(1, 62))};
    for (int p = 0; p < 4; p++) begin
      set_threshold(phase_thr[p]);
      steady = (p == 2);
      for (int n = 0; n < 200; n++) offer_connection(pick_pair(24 + 12 * p), 1'b0, '0);
    end
    steady = 1'b0;

    // fill up to one free slot, then run into the full table from every side
    set_threshold(6'd1);
    nxt = 60;
    while (used_cnt < HOSTS - 1) begin
      offer_connection(mk_item(host_tab[$urandom_range(used_cnt - 1)], host_list[nxt]),
                       1'b0, '0);
      nxt++;
    end
    offer_connection(mk_item(host_list[nxt], host_list[nxt + 1]), 1'b0, '0);
    offer_connection(mk_item(host_list[nxt + 2], host_tab[1]), 1'b0, '0);
    offer_connection(mk_item(host_tab[2], host_list[nxt + 3]), 1'b0, '0);
    offer_connection(mk_item(host_list[nxt + 4], host_list[nxt + 5]), 1'b0, '0);

    // hub: slot 0 peers with every other host, degree up to 63
    set_threshold(6'd63);
    for (int s = 1; s < HOSTS; s++) begin
      if ($urandom_range(1) == 1) offer_connection(mk_item(host_tab[0], host_tab[s]), 1'b0, '0);
      else offer_connection(mk_item(host_tab[s], host_tab[0]), 1'b0, '0);
    end

    set_threshold(hft_pkg::degree_t'($urandom_range(1, 62)));
    for (int n = 0; n < 150; n++) offer_connection(pick_late_pair(), 1'b0, '0);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/hft_pkg.sv
rtl/host_fanout_tracker.sv
sim/tb_host_fanout_tracker.sv
